@@ rtl/ps2hp_pkg.sv @@
// ps2hp_pkg: shared types and constants of the ps2 host port engine
`timescale 1ns / 1ps

package ps2hp_pkg;

	// item opcodes
	localparam logic OP_CLK_EDGE = 1'b0;
	localparam logic OP_SEND     = 1'b1;

	// port phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RECV = 2'd1;
	localparam logic [1:0] PH_SEND = 2'd2;

	// device response bytes
	localparam logic [7:0] BYTE_ACK    = 8'hFA;
	localparam logic [7:0] BYTE_ERROR  = 8'hFC;
	localparam logic [7:0] BYTE_RESEND = 8'hFE;

	// frame positions counted in clock edges after the start bit
	localparam logic [3:0] BIT_PARITY = 4'd9;
	localparam logic [3:0] BIT_STOP   = 4'd10;

	// response codes
	localparam logic RESP_ACK   = 1'b0;
	localparam logic RESP_ERROR = 1'b1;

	localparam logic [2:0] ATTEMPTS_RESET = 3'd3;

	typedef struct packed {
		logic       opcode;
		logic       data_bit;
		logic [7:0] send_byte;
	} item_t;

	typedef struct packed {
		logic       data_drive_enable;
		logic       data_drive_level;
		logic       request_to_send;
		logic       byte_valid;
		logic [7:0] received_byte;
		logic       response_valid;
		logic       response_code;
		logic       port_busy;
	} result_t;

endpackage

@@ rtl/ps2hp_core.sv @@
// ps2hp_core: port state registers and the per-request update logic
`timescale 1ns / 1ps

module ps2hp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  ps2hp_pkg::item_t   item,
	input  logic [2:0]         send_attempts,
	output ps2hp_pkg::result_t result
);

	logic [1:0] phase_q,         phase_d;
	logic [3:0] bit_count_q,     bit_count_d;
	logic [7:0] shift_in_q,      shift_in_d;
	logic [7:0] shift_out_q,     shift_out_d;
	logic [7:0] held_byte_q,     held_byte_d;
	logic       parity_acc_q,    parity_acc_d;
	logic [2:0] attempts_left_q, attempts_left_d;
	logic       drive_en_q,      drive_en_d;
	logic       drive_lvl_q,     drive_lvl_d;

	logic [3:0] bit_count_inc;
	logic       rts, bvalid, rvalid, rcode;
	logic [7:0] rbyte;

	assign bit_count_inc = bit_count_q + 4'd1;

	always_comb begin
		phase_d         = phase_q;
		bit_count_d     = bit_count_q;
		shift_in_d      = shift_in_q;
		shift_out_d     = shift_out_q;
		held_byte_d     = held_byte_q;
		parity_acc_d    = parity_acc_q;
		attempts_left_d = attempts_left_q;
		drive_en_d      = drive_en_q;
		drive_lvl_d     = drive_lvl_q;
		rts             = 1'b0;
		bvalid          = 1'b0;
		rbyte           = 8'd0;
		rvalid          = 1'b0;
		rcode           = ps2hp_pkg::RESP_ACK;

		if (item.opcode == ps2hp_pkg::OP_SEND) begin
			if (phase_q == ps2hp_pkg::PH_RECV || phase_q == ps2hp_pkg::PH_SEND) begin
				// refused while busy
				rvalid = 1'b1;
				rcode  = ps2hp_pkg::RESP_ERROR;
			end else begin
				held_byte_d     = item.send_byte;
				attempts_left_d = send_attempts;
				rts             = 1'b1;
				shift_out_d     = item.send_byte;
				bit_count_d     = 4'd0;
				parity_acc_d    = 1'b0;
				drive_en_d      = 1'b1;
				drive_lvl_d     = 1'b0;
				phase_d         = ps2hp_pkg::PH_SEND;
			end
		end else begin
			unique case (phase_q)
				ps2hp_pkg::PH_SEND: begin
					bit_count_d = bit_count_inc;
					if (bit_count_inc < ps2hp_pkg::BIT_PARITY) begin
						drive_lvl_d  = shift_out_q[0];
						parity_acc_d = parity_acc_q ^ shift_out_q[0];
						shift_out_d  = {1'b0, shift_out_q[7:1]};
					end else if (bit_count_inc == ps2hp_pkg::BIT_PARITY) begin
						drive_lvl_d = ~parity_acc_q;
					end else if (bit_count_inc == ps2hp_pkg::BIT_STOP) begin
						drive_lvl_d = 1'b1;
					end else begin
						// ack edge from the device
						drive_en_d = 1'b0;
						phase_d    = ps2hp_pkg::PH_IDLE;
					end
				end
				ps2hp_pkg::PH_RECV: begin
					bit_count_d = bit_count_inc;
					if (bit_count_inc < ps2hp_pkg::BIT_PARITY) begin
						shift_in_d   = {item.data_bit, shift_in_q[7:1]};
						parity_acc_d = parity_acc_q ^ item.data_bit;
					end else if (bit_count_inc >= ps2hp_pkg::BIT_STOP) begin
						if (shift_in_q == ps2hp_pkg::BYTE_RESEND &&
						    attempts_left_q > 3'd1) begin
							attempts_left_d = attempts_left_q - 3'd1;
							rts             = 1'b1;
							shift_out_d     = held_byte_q;
							bit_count_d     = 4'd0;
							parity_acc_d    = 1'b0;
							drive_en_d      = 1'b1;
							drive_lvl_d     = 1'b0;
							phase_d         = ps2hp_pkg::PH_SEND;
						end else begin
							rvalid     = 1'b1;
							rcode      = (shift_in_q == ps2hp_pkg::BYTE_ACK) ?
							             ps2hp_pkg::RESP_ACK : ps2hp_pkg::RESP_ERROR;
							drive_en_d = 1'b0;
							phase_d    = ps2hp_pkg::PH_IDLE;
							if (shift_in_q == ps2hp_pkg::BYTE_RESEND) begin
								attempts_left_d = 3'd0;
							end else if (shift_in_q != ps2hp_pkg::BYTE_ACK &&
							             shift_in_q != ps2hp_pkg::BYTE_ERROR) begin
								// unsolicited byte is forwarded
								bvalid = 1'b1;
								rbyte  = shift_in_q;
							end
						end
					end
				end
				default: begin
					// idle, and the unused code behaves as idle
					phase_d = ps2hp_pkg::PH_IDLE;
					if (!item.data_bit) begin
						shift_in_d   = 8'd0;
						bit_count_d  = 4'd0;
						parity_acc_d = 1'b0;
						phase_d      = ps2hp_pkg::PH_RECV;
					end
				end
			endcase
		end
	end

	always_comb begin
		result.data_drive_enable = drive_en_d;
		result.data_drive_level  = drive_lvl_d;
		result.request_to_send   = rts;
		result.byte_valid        = bvalid;
		result.received_byte     = rbyte;
		result.response_valid    = rvalid;
		result.response_code     = rcode;
		result.port_busy         = (phase_d == ps2hp_pkg::PH_RECV) ||
		                           (phase_d == ps2hp_pkg::PH_SEND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= ps2hp_pkg::PH_IDLE;
			bit_count_q     <= 4'd0;
			shift_in_q      <= 8'd0;
			shift_out_q     <= 8'd0;
			held_byte_q     <= 8'd0;
			parity_acc_q    <= 1'b0;
			attempts_left_q <= 3'd0;
			drive_en_q      <= 1'b0;
			drive_lvl_q     <= 1'b1;
		end else if (step) begin
			phase_q         <= phase_d;
			bit_count_q     <= bit_count_d;
			shift_in_q      <= shift_in_d;
			shift_out_q     <= shift_out_d;
			held_byte_q     <= held_byte_d;
			parity_acc_q    <= parity_acc_d;
			attempts_left_q <= attempts_left_d;
			drive_en_q      <= drive_en_d;
			drive_lvl_q     <= drive_lvl_d;
		end
	end

endmodule

@@ rtl/ps2hp_out_reg.sv @@
// ps2hp_out_reg: result register with valid/ready towards the receiver
`timescale 1ns / 1ps

module ps2hp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ps2hp_pkg::result_t load_data,
	output logic               can_load,
	output logic               result_valid,
	input  logic               result_ready,
	output ps2hp_pkg::result_t result
);

	logic               valid_q;
	ps2hp_pkg::result_t data_q;

	// a new request may enter when the slot is empty or drains this cycle
	assign can_load     = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

@@ rtl/ps2hp_cfg.sv @@
// ps2hp_cfg: send attempts configuration register
`timescale 1ns / 1ps

module ps2hp_cfg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data,
	output logic [2:0] send_attempts
);

	logic [2:0] send_attempts_q;

	assign cfg_ready     = 1'b1;
	assign send_attempts = send_attempts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_attempts_q <= ps2hp_pkg::ATTEMPTS_RESET;
		end else if (cfg_valid) begin
			send_attempts_q <= cfg_data;
		end
	end

endmodule

@@ rtl/ps2_host_port_engine_top.sv @@
// ps2_host_port_engine_top: ps2 host port engine top level
// Usage:
//   item channel (item_valid/item_ready/item): one request per observed falling
//   edge of the ps2 clock line (opcode 0, with the sampled data level) or per
//   host send request (opcode 1, with the byte to send).
//   result channel (result_valid/result_ready/result): exactly one result per
//   request, carrying the data line drive, request-to-send pulse, forwarded
//   byte, send response and busy flag after that request.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the send attempts
//   register; always ready, write it only while the port is idle.
// The port state and the result register update on the edge that takes
//   the request. Throughput is one request per cycle, set by
//   the single result register; item_ready stays high while the result
//   register is empty or being taken in the same cycle.
// When the receiver stalls, the held result stays put and item_ready drops
//   until it is taken; the port state advances only on taken requests.
// Reset (arst_n low) returns the port to idle with the data line released at
//   level one, empties the result register and sets send attempts to three.
`timescale 1ns / 1ps

module ps2_host_port_engine_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  ps2hp_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output ps2hp_pkg::result_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_data
);

	logic               step;
	logic               can_load;
	logic [2:0]         send_attempts;
	ps2hp_pkg::result_t next_result;

	assign item_ready = can_load;
	assign step       = item_valid && can_load;

	ps2hp_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.send_attempts (send_attempts)
	);

	ps2hp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.item          (item),
		.send_attempts (send_attempts),
		.result        (next_result)
	);

	ps2hp_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.load_data    (next_result),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
